// ----- hdl/wat_pkg.sv -----
// ---------------------------------------------------------------------------
// Weekly alarm table package
// Shared types, codes and constants for the weekly alarm table core.
// ---------------------------------------------------------------------------
`default_nettype none

package wat_pkg;

  // Table geometry.
  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Time limits and second counts.
  localparam int MAX_HOUR   = 23;
  localparam int MAX_MINUTE = 59;
  localparam int HOUR_SECS  = 3600;
  localparam int MIN_SECS   = 60;
  localparam int DAY_SECS   = 86400;
  localparam int WEEK_DAYS  = 7;

  // Operation codes.
  typedef enum logic [2:0] {
    FUNC_ADD    = 3'd0,
    FUNC_REMOVE = 3'd1,
    FUNC_ENABLE = 3'd2,
    FUNC_UPDATE = 3'd3,
    FUNC_TICK   = 3'd4
  } func_t;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_ACK   = 2'd0,
    KIND_FIRED = 2'd1,
    KIND_DONE  = 2'd2
  } kind_t;

  // Status codes.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_TIME  = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_NO_IDS    = 3'd4
  } status_t;

  // One input item.
  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] target_id;
    logic [4:0]  set_hour;
    logic [5:0]  set_minute;
    logic [6:0]  set_days;
    logic        set_enable;
    logic [4:0]  now_hour;
    logic [5:0]  now_minute;
    logic [5:0]  now_second;
    logic [2:0]  now_weekday;
  } req_t;

  // One result item.
  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  status;
    logic [15:0] alarm_id;
    logic [4:0]  alarm_hour;
    logic [5:0]  alarm_minute;
    logic [19:0] next_alarm_seconds;
    logic [4:0]  alarm_count;
    logic [4:0]  active_count;
    logic        last;
  } rsp_t;

  // One stored alarm.
  typedef struct packed {
    logic [15:0] id;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [6:0]  days;
    logic        en;
  } entry_t;

  // One fired alarm waiting to be reported.
  typedef struct packed {
    logic [15:0] id;
    logic [4:0]  hour;
    logic [5:0]  minute;
  } fired_t;

endpackage

`default_nettype wire

// ----- hdl/weekly_alarm_table_core.sv -----
// Sequence: add and unknown operations, and items rejected before a scan, go from idle
// straight to the final result; remove, set enable, update and tick scan the table,
// reading and then evaluating each stored entry in turn, and a tick then reads out and
// reports each fired alarm before the final result. Each result waits while the output is full.
// Throughput: one item at a time; the next item is accepted once the final result is loaded.
// Reset: the table is empty, the next id is 1 and the last checked minute is 0.
// ---------------------------------------------------------------------------
// Weekly alarm table core
// Compacted alarm table with add, remove, enable, update and minute ticks.
// ---------------------------------------------------------------------------
`default_nettype none

module weekly_alarm_table_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  wat_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output wat_pkg::rsp_t rsp
);
  import wat_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD   = 6'b000010,
    S_EV   = 6'b000100,
    S_FRD  = 6'b001000,
    S_FOUT = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t state;

  // Table and fired-alarm buffer.
  entry_t mem [DEPTH];
  entry_t rdata;
  fired_t fbuf [DEPTH];
  fired_t fdata;

  // Control and counters.
  req_t              op;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  active;
  logic [16:0]       next_id;
  logic [10:0]       lcm;
  logic [CNT_W-1:0]  r;
  logic [CNT_W-1:0]  w;
  logic [CNT_W-1:0]  acc;
  logic [CNT_W-1:0]  fcnt;
  logic [CNT_W-1:0]  rp;
  logic              found;
  logic              fire_on;
  logic [16:0]       cur;
  logic              bvalid;
  logic [19:0]       best;
  logic [2:0]        fin_status;
  logic [15:0]       fin_id;

  logic              bad_time;
  logic [10:0]       stamp;
  logic              is_tick;
  logic              match;
  logic              fire;
  logic              drop;
  entry_t            mod_e;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_data;
  logic              d_hit;
  logic [19:0]       d_secs;
  logic              out_free;
  logic              rsp_load;
  logic              add_ok;
  logic              tick_fire;
  status_t           idle_status;
  state_t            idle_next;

  assign req_ready = (state == S_IDLE);
  assign out_free  = !rsp_valid || rsp_ready;
  assign rsp_load  = out_free && (state == S_FOUT || state == S_FIN);
  assign bad_time  = (req.set_hour > 5'(MAX_HOUR)) || (req.set_minute > 6'(MAX_MINUTE));
  assign stamp     = 11'(req.now_hour) * 11'(MIN_SECS) + 11'(req.now_minute);
  assign is_tick   = (op.func == FUNC_TICK);

  // Decision taken when an item is accepted.
  always_comb begin
    add_ok      = (req.func == FUNC_ADD) && !bad_time && (cnt < CNT_W'(DEPTH)) &&
                  !next_id[16];
    tick_fire   = (req.func == FUNC_TICK) && (cnt != '0) && (stamp != lcm);
    idle_status = ST_OK;
    idle_next   = S_FIN;
    case (req.func)
      FUNC_ADD: begin
        if (bad_time) begin
          idle_status = ST_BAD_TIME;
        end else if (cnt >= CNT_W'(DEPTH)) begin
          idle_status = ST_FULL;
        end else if (next_id[16]) begin
          idle_status = ST_NO_IDS;
        end
      end
      FUNC_REMOVE, FUNC_ENABLE, FUNC_UPDATE: begin
        if (req.func == FUNC_UPDATE && bad_time) begin
          idle_status = ST_BAD_TIME;
        end else if (cnt == '0) begin
          idle_status = ST_NOT_FOUND;
        end else begin
          idle_next = S_RD;
        end
      end
      FUNC_TICK: begin
        if (cnt != '0) begin
          idle_next = S_RD;
        end
      end
      default: begin
        idle_status = ST_OK;
      end
    endcase
  end

  // Per-entry decision during a scan.
  always_comb begin
    match = (rdata.id == op.target_id);
    fire  = fire_on && rdata.en && (rdata.hour == op.now_hour) &&
            (rdata.minute == op.now_minute) &&
            ((rdata.days == '0) ||
             ((op.now_weekday < 3'(WEEK_DAYS)) && rdata.days[op.now_weekday[2:0]]));
    drop  = (is_tick && fire && rdata.days == '0) ||
            (op.func == FUNC_REMOVE && match);
    mod_e = rdata;
    if (op.func == FUNC_ENABLE && match) begin
      mod_e.en = op.set_enable;
    end
    if (op.func == FUNC_UPDATE && match) begin
      mod_e.hour   = op.set_hour;
      mod_e.minute = op.set_minute;
      mod_e.days   = op.set_days;
    end
  end

  wat_dist u_dist (
    .ent  (mod_e),
    .cur  (cur),
    .nw   (op.now_weekday),
    .hit  (d_hit),
    .secs (d_secs)
  );

  // Table write port: append on add, compacting write-back during a scan.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = w[IDX_W-1:0];
    wr_data = mod_e;
    if (state == S_IDLE && req_valid && add_ok) begin
      wr_en   = 1'b1;
      wr_addr = cnt[IDX_W-1:0];
      wr_data = '{id: next_id[15:0], hour: req.set_hour, minute: req.set_minute,
                  days: req.set_days, en: 1'b1};
    end else if (state == S_EV && !drop) begin
      wr_en = 1'b1;
    end
  end

  // Table memory with registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[r[IDX_W-1:0]];
  end

  // Fired-alarm buffer.
  always_ff @(posedge clk) begin
    if (state == S_EV && is_tick && fire) begin
      fbuf[fcnt[IDX_W-1:0]] <= '{id: rdata.id, hour: rdata.hour, minute: rdata.minute};
    end
    fdata <= fbuf[rp[IDX_W-1:0]];
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      active    <= '0;
      next_id   <= 17'd1;
      lcm       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            op         <= req;
            fin_status <= idle_status;
            fin_id     <= add_ok ? next_id[15:0] : '0;
            r          <= '0;
            w          <= '0;
            acc        <= '0;
            fcnt       <= '0;
            rp         <= '0;
            found      <= 1'b0;
            bvalid     <= 1'b0;
            best       <= '0;
            fire_on    <= tick_fire;
            cur        <= 17'(req.now_hour) * 17'(HOUR_SECS) +
                          17'(req.now_minute) * 17'(MIN_SECS) + 17'(req.now_second);
            state      <= idle_next;
            if (add_ok) begin
              cnt     <= cnt + CNT_W'(1);
              active  <= active + CNT_W'(1);
              next_id <= next_id + 17'd1;
            end
            if (tick_fire) begin
              lcm <= stamp;
            end
          end
        end
        S_RD: begin
          state <= S_EV;
        end
        S_EV: begin
          if (match && op.func != FUNC_TICK) begin
            found <= 1'b1;
          end
          if (is_tick && fire) begin
            fcnt <= fcnt + CNT_W'(1);
          end
          if (!drop) begin
            w <= w + CNT_W'(1);
            if (mod_e.en) begin
              acc <= acc + CNT_W'(1);
            end
            if (d_hit && (!bvalid || d_secs < best)) begin
              bvalid <= 1'b1;
              best   <= d_secs;
            end
          end
          r <= r + CNT_W'(1);
          if (r + CNT_W'(1) >= cnt) begin
            cnt    <= drop ? w : w + CNT_W'(1);
            active <= (!drop && mod_e.en) ? acc + CNT_W'(1) : acc;
            if (!is_tick) begin
              fin_status <= (found || match) ? ST_OK : ST_NOT_FOUND;
            end
            state <= (is_tick && (fire || fcnt != '0)) ? S_FRD : S_FIN;
          end else begin
            state <= S_RD;
          end
        end
        S_FRD: begin
          state <= S_FOUT;
        end
        S_FOUT: begin
          if (out_free) begin
            rsp       <= '{kind: KIND_FIRED, status: ST_OK, alarm_id: fdata.id,
                           alarm_hour: fdata.hour, alarm_minute: fdata.minute,
                           next_alarm_seconds: '0, alarm_count: cnt,
                           active_count: active, last: 1'b0};
            rp        <= rp + CNT_W'(1);
            state     <= (rp + CNT_W'(1) < fcnt) ? S_FRD : S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            rsp       <= '{kind: is_tick ? KIND_DONE : KIND_ACK, status: fin_status,
                           alarm_id: fin_id, alarm_hour: '0, alarm_minute: '0,
                           next_alarm_seconds: is_tick ? best : '0,
                           alarm_count: cnt, active_count: active, last: 1'b1};
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  // The table never holds more alarms than it has rows.
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(DEPTH)) else $error("entry count above table depth");

  // Enabled alarms are a subset of stored alarms while idle.
  a_active_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> active <= cnt) else $error("active count above entry count");

  // An accepted item always leaves the idle state.
  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> state != S_IDLE) else $error("item accepted but still idle");

  // Fired alarms drained from the buffer never outrun those stored in it.
  a_drain: assert property (@(posedge clk) disable iff (rst)
    state == S_FOUT |-> rp < fcnt) else $error("fired buffer read past its fill");
`endif

endmodule

`default_nettype wire

// ----- hdl/wat_dist.sv -----
// ---------------------------------------------------------------------------
// Weekly alarm table distance unit
// Seconds from the current time to the next occurrence of one alarm.
// ---------------------------------------------------------------------------
`default_nettype none

module wat_dist (
  input  wat_pkg::entry_t ent,
  input  logic [16:0]     cur,
  input  logic [2:0]      nw,
  output logic            hit,
  output logic [19:0]     secs
);
  import wat_pkg::*;

  logic [16:0]        at;
  logic signed [17:0] diff;
  logic signed [20:0] dd;
  logic [3:0]         sum;
  logic [2:0]         wd;

  // Alarm time of day, then the first masked day with a positive distance, or today only when no day is masked.
  always_comb begin
    hit  = 1'b0;
    secs = '0;
    dd   = '0;
    sum  = '0;
    wd   = '0;
    at   = 17'(ent.hour) * 17'(HOUR_SECS) + 17'(ent.minute) * 17'(MIN_SECS);
    diff = $signed({1'b0, at}) - $signed({1'b0, cur});
    if (ent.en) begin
      if (ent.days == '0) begin
        if (diff > 0) begin
          hit  = 1'b1;
          secs = 20'(diff);
        end
      end else begin
        for (int d = 0; d < WEEK_DAYS; d++) begin
          sum = 4'(nw) + 4'(d);
          wd  = (sum >= 4'(WEEK_DAYS)) ? 3'(sum - 4'(WEEK_DAYS)) : 3'(sum);
          dd  = $signed(21'(diff)) + $signed(21'(d) * 21'(DAY_SECS));
          if (!hit && ent.days[wd] && dd > 0) begin
            hit  = 1'b1;
            secs = 20'(dd);
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- tb/sv/weekly_alarm_table_core_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Weekly alarm table core test
// Drives operations and minute ticks through the request channel and checks
// every result against an in-bench model of the alarm table, with random
// stalls on both channels and a final pass that empties the table.
// ---------------------------------------------------------------------------
module weekly_alarm_table_core_test;
  import wat_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  int send_idle = 11;
  int recv_idle = 53;
  int mismatches = 0;
  bit stray = 1'b0;

  // Model of the alarm table.
  entry_t alarms[DEPTH];
  int alarm_total = 0;
  logic [16:0] id_counter = 17'd1;
  logic [10:0] checked_minute = '0;
  rsp_t pending_results[$];

  // A directed stimulus row; typed results replace the model's prediction.
  typedef struct {
    req_t op;
    bit   typed;
    rsp_t result;
  } row_t;
  row_t rows[$];

  weekly_alarm_table_core u_top (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int find_alarm(logic [15:0] id);
    for (int i = 0; i < alarm_total; i++) begin
      if (alarms[i].id == id) return i;
    end
    return -1;
  endfunction

  function automatic void drop_alarm(int idx);
    for (int i = idx; i + 1 < alarm_total; i++) alarms[i] = alarms[i + 1];
    alarm_total--;
  endfunction

  // Seconds until the nearest enabled alarm, zero when there is none.
  function automatic logic [19:0] seconds_to_next(req_t r);
    longint cur;
    longint best;
    longint at;
    longint gap;
    int wd;
    cur = longint'(r.now_hour) * 3600 + longint'(r.now_minute) * 60 +
          longint'(r.now_second);
    best = -1;
    for (int i = 0; i < alarm_total; i++) begin
      if (!alarms[i].en) continue;
      at = longint'(alarms[i].hour) * 3600 + longint'(alarms[i].minute) * 60;
      if (alarms[i].days == 0) begin
        if (at > cur && (best < 0 || at - cur < best)) best = at - cur;
        continue;
      end
      for (int d = 0; d < WEEK_DAYS; d++) begin
        wd = (int'(r.now_weekday) + d) % WEEK_DAYS;
        if (!alarms[i].days[wd]) continue;
        gap = longint'(d) * DAY_SECS + at - cur;
        if (gap <= 0) continue;
        if (best < 0 || gap < best) best = gap;
        break;
      end
    end
    return best < 0 ? 20'd0 : best[19:0];
  endfunction

  function automatic rsp_t make_result(kind_t k, status_t s, logic [15:0] id);
    rsp_t o;
    o = '0;
    o.kind = k;
    o.status = s;
    o.alarm_id = id;
    return o;
  endfunction

  // Works out the results of one accepted item and updates the model.
  function automatic void predict_alarm_results(req_t r);
    rsp_t outs[$];
    rsp_t o;
    entry_t e;
    int idx;
    int i;
    int active;
    int stamp;
    bit bad_time;
    bad_time = (r.set_hour > MAX_HOUR) || (r.set_minute > MAX_MINUTE);
    case (r.func)
      FUNC_ADD: begin
        if (bad_time) outs = {outs, make_result(KIND_ACK, ST_BAD_TIME, '0)};
        else if (alarm_total >= DEPTH) outs = {outs, make_result(KIND_ACK, ST_FULL, '0)};
        else if (id_counter > 17'd65535) outs = {outs, make_result(KIND_ACK, ST_NO_IDS, '0)};
        else begin
          alarms[alarm_total] = '{id: id_counter[15:0], hour: r.set_hour,
                                  minute: r.set_minute, days: r.set_days, en: 1'b1};
          alarm_total++;
          outs = {outs, make_result(KIND_ACK, ST_OK, id_counter[15:0])};
          id_counter++;
        end
      end
      FUNC_REMOVE, FUNC_ENABLE: begin
        idx = find_alarm(r.target_id);
        if (idx < 0) outs = {outs, make_result(KIND_ACK, ST_NOT_FOUND, '0)};
        else begin
          if (r.func == FUNC_REMOVE) drop_alarm(idx);
          else alarms[idx].en = r.set_enable;
          outs = {outs, make_result(KIND_ACK, ST_OK, '0)};
        end
      end
      FUNC_UPDATE: begin
        idx = find_alarm(r.target_id);
        if (bad_time) outs = {outs, make_result(KIND_ACK, ST_BAD_TIME, '0)};
        else if (idx < 0) outs = {outs, make_result(KIND_ACK, ST_NOT_FOUND, '0)};
        else begin
          alarms[idx].hour = r.set_hour;
          alarms[idx].minute = r.set_minute;
          alarms[idx].days = r.set_days;
          outs = {outs, make_result(KIND_ACK, ST_OK, '0)};
        end
      end
      FUNC_TICK: begin
        stamp = int'(r.now_hour) * 60 + int'(r.now_minute);
        if (alarm_total != 0 && stamp != int'(checked_minute)) begin
          checked_minute = stamp[10:0];
          i = 0;
          while (i < alarm_total) begin
            e = alarms[i];
            if (e.en && e.hour == r.now_hour && e.minute == r.now_minute) begin
              o = make_result(KIND_FIRED, ST_OK, e.id);
              o.alarm_hour = e.hour;
              o.alarm_minute = e.minute;
              // One-shot alarms go away once they have fired.
              if (e.days == 0) begin
                outs = {outs, o};
                drop_alarm(i);
                continue;
              end
              if (r.now_weekday < WEEK_DAYS && e.days[r.now_weekday]) outs = {outs, o};
            end
            i++;
          end
        end
        o = make_result(KIND_DONE, ST_OK, '0);
        o.next_alarm_seconds = seconds_to_next(r);
        outs = {outs, o};
      end
      default: outs = {outs, make_result(KIND_ACK, ST_OK, '0)};
    endcase
    active = 0;
    for (int j = 0; j < alarm_total; j++) if (alarms[j].en) active++;
    foreach (outs[k]) begin
      outs[k].alarm_count = 5'(alarm_total);
      outs[k].active_count = 5'(active);
      outs[k].last = (k == outs.size() - 1);
      pending_results = {pending_results, outs[k]};
    end
  endfunction

  // Prediction on acceptance and checking of results, both at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) predict_alarm_results(req);
      if (rsp_valid && rsp_ready) begin
        if (pending_results.size() == 0) begin
          stray = 1'b1;
          if (mismatches < 10) $display("Unexpected result %p", rsp);
          mismatches++;
        end else begin
          if (rsp !== pending_results[0]) begin
            if (mismatches < 10)
              $display("Mismatch: expected %p, got %p", pending_results[0], rsp);
            mismatches++;
          end
          void'(pending_results.pop_front());
        end
      end
    end
  end

  // Receiver stalls.
  always @(negedge clk) rsp_ready = ($urandom_range(99) >= recv_idle);

  function automatic req_t make_op(func_t f, int id, int sh, int sm, int sd, int se,
                                   int nh, int nm, int ns, int nw);
    req_t r;
    r.func = f;
    r.target_id = 16'(id);
    r.set_hour = 5'(sh);
    r.set_minute = 6'(sm);
    r.set_days = 7'(sd);
    r.set_enable = 1'(se);
    r.now_hour = 5'(nh);
    r.now_minute = 6'(nm);
    r.now_second = 6'(ns);
    r.now_weekday = 3'(nw);
    return r;
  endfunction

  function automatic void add_row(req_t op, bit typed, rsp_t result);
    row_t w;
    w.op = op;
    w.typed = typed;
    w.result = result;
    rows = {rows, w};
  endfunction

  function automatic rsp_t ack(status_t s, int id, int total, int active);
    rsp_t o;
    o = make_result(KIND_ACK, s, 16'(id));
    o.alarm_count = 5'(total);
    o.active_count = 5'(active);
    o.last = 1'b1;
    return o;
  endfunction

  // Presents one item at a falling edge and holds it until it is accepted.
  task automatic send(req_t r);
    while ($urandom_range(99) < send_idle) @(negedge clk);
    req = r;
    req_valid = 1'b1;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
    req_valid = 1'b0;
  endtask

  // A random item, weighted towards ids and times that are in the table.
  function automatic req_t random_op();
    req_t r;
    logic [63:0] raw;
    int pick;
    int j;
    raw = {$urandom(), $urandom()};
    r = raw[$bits(req_t)-1:0];
    r.now_hour = 5'($urandom_range(23));
    r.now_minute = 6'($urandom_range(59));
    r.now_second = 6'($urandom_range(59));
    r.now_weekday = ($urandom_range(19) == 0) ? 3'd7 : 3'($urandom_range(6));
    if ($urandom_range(9) != 0) begin
      r.set_hour = 5'($urandom_range(23));
      r.set_minute = 6'($urandom_range(59));
    end
    if ($urandom_range(3) == 0) r.set_days = '0;
    if (alarm_total > 0 && $urandom_range(4) != 0) begin
      j = int'($urandom_range(alarm_total - 1));
      r.target_id = alarms[j].id;
      if ($urandom_range(1) == 0) begin
        r.now_hour = alarms[j].hour;
        r.now_minute = alarms[j].minute;
      end
    end
    pick = int'($urandom_range(99));
    if (pick < 30) r.func = FUNC_ADD;
    else if (pick < 45) r.func = FUNC_REMOVE;
    else if (pick < 55) r.func = FUNC_ENABLE;
    else if (pick < 70) r.func = FUNC_UPDATE;
    else if (pick < 95) r.func = FUNC_TICK;
    else r.func = func_t'($urandom_range(7, 5));
    return r;
  endfunction

  initial begin
    rsp_t done;
    done = make_result(KIND_DONE, ST_OK, '0);
    done.last = 1'b1;

    // Directed rows: extremes, every operation, skipped ticks and odd weekdays.
    add_row(make_op(FUNC_TICK, 0, 0, 0, 0, 0, 23, 59, 59, 6), 1, done);
    add_row(make_op(FUNC_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, ack(ST_NOT_FOUND, 0, 0, 0));
    add_row(make_op(FUNC_ADD, 0, 24, 0, 0, 0, 0, 0, 0, 0), 1, ack(ST_BAD_TIME, 0, 0, 0));
    add_row(make_op(FUNC_ADD, 0, 0, 60, 0, 0, 0, 0, 0, 0), 1, ack(ST_BAD_TIME, 0, 0, 0));
    add_row(make_op(FUNC_ADD, 0, 23, 59, 0, 0, 0, 0, 0, 0), 1, ack(ST_OK, 1, 1, 1));
    add_row(make_op(FUNC_ADD, 0, 0, 0, 127, 0, 0, 0, 0, 0), 1, ack(ST_OK, 2, 2, 2));
    add_row(make_op(FUNC_UPDATE, 1, 31, 63, 127, 1, 0, 0, 0, 0), 1,
            ack(ST_BAD_TIME, 0, 2, 2));
    add_row(make_op(FUNC_UPDATE, 65535, 5, 5, 5, 0, 0, 0, 0, 0), 1,
            ack(ST_NOT_FOUND, 0, 2, 2));
    add_row(make_op(FUNC_ENABLE, 2, 0, 0, 0, 0, 0, 0, 0, 0), 1, ack(ST_OK, 0, 2, 1));
    add_row(make_op(FUNC_ENABLE, 0, 0, 0, 0, 1, 0, 0, 0, 0), 1, ack(ST_NOT_FOUND, 0, 2, 1));
    add_row(make_op(FUNC_ENABLE, 2, 0, 0, 0, 1, 0, 0, 0, 0), 1, ack(ST_OK, 0, 2, 2));
    add_row(make_op(func_t'(5), 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, ack(ST_OK, 0, 2, 2));
    add_row(make_op(func_t'(7), 65535, 31, 63, 127, 1, 31, 63, 63, 7), 1,
            ack(ST_OK, 0, 2, 2));
    add_row(make_op(FUNC_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, done);
    add_row(make_op(FUNC_TICK, 0, 0, 0, 0, 0, 0, 1, 0, 0), 0, done);
    add_row(make_op(FUNC_TICK, 0, 0, 0, 0, 0, 0, 1, 30, 3), 0, done);
    add_row(make_op(FUNC_UPDATE, 2, 12, 30, 64, 0, 0, 0, 0, 0), 0, done);
    add_row(make_op(FUNC_TICK, 0, 0, 0, 0, 0, 12, 30, 0, 6), 0, done);
    add_row(make_op(FUNC_TICK, 0, 0, 0, 0, 0, 23, 59, 0, 7), 0, done);
    add_row(make_op(FUNC_TICK, 0, 0, 0, 0, 0, 12, 30, 0, 6), 0, done);
    add_row(make_op(FUNC_TICK, 0, 0, 0, 0, 0, 12, 29, 59, 0), 0, done);
    add_row(make_op(FUNC_REMOVE, 2, 0, 0, 0, 0, 0, 0, 0, 0), 0, done);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // A typed row gives one result, the newest one predicted.
    foreach (rows[i]) begin
      send(rows[i].op);
      if (rows[i].typed) pending_results[pending_results.size() - 1] = rows[i].result;
    end

    // Random items in three idling patterns.
    for (int p = 0; p < 3; p++) begin
      send_idle = (p == 0) ? 11 : (p == 1) ? 53 : 0;
      recv_idle = (p == 0) ? 53 : (p == 1) ? 11 : 0;
      repeat (145) send(random_op());
    end

    // Empty the table.
    while (alarm_total > 0) send(make_op(FUNC_REMOVE, alarms[0].id, 0, 0, 0, 0, 0, 0, 0, 0));

    while (pending_results.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && !stray && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #60_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
